// ===== design/sti_pkg.sv =====
// Shared constants, codes and transaction types for the sorted table.
// No dependencies; imported by sti_store and sorted_table_insert_remove.
`default_nettype none

package sti_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [ADDR_WIDTH-1:0]    index;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] data;
        logic [1:0]               status;
        logic                     last;
        logic [CNT_WIDTH-1:0]     count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/sorted_table_insert_remove.sv =====
// Top level of the sorted table: request/response channels and the sequencer.
// Depends on sti_pkg and sti_store.
`default_nettype none

// Keeps up to 64 signed 32-bit values in ascending order in a single-port-write,
// registered-read memory, and takes one request at a time (req_ready is low while
// a request is worked). Every entry move goes through the one memory port pair,
// one entry per cycle, and insert finds its slot with the one signed comparator.
// Insert shifts each entry larger than the value up by one, remove shifts the
// entries above the index down by one, and dump emits one response per entry; a
// full insert, a bad index or an empty dump goes straight to S_EMIT. The
// response sits in an output register, so a new request can be taken while the
// last response waits for rsp_ready.
module sorted_table_insert_remove
    import sti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_RM_RD,
        S_RM_TAKE,
        S_RM_MOVE,
        S_RM_DONE,
        S_DMP_RD,
        S_DMP_WAIT,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [CNT_WIDTH-1:0]   ptr_reg, ptr_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [VALUE_WIDTH-1:0] res_data_reg, res_data_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic                   res_last_reg, res_last_next;
    logic                   dump_more_reg, dump_more_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg, out_next;

    logic                   mem_we;
    logic [ADDR_WIDTH-1:0]  mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [ADDR_WIDTH-1:0]  mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    logic [CNT_WIDTH-1:0]   ptr_m1, ptr_m2, ptr_p1, ptr_p2;
    logic                   greater;
    logic                   req_fire;

    sti_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign ptr_m1   = ptr_reg - CNT_WIDTH'(1);
    assign ptr_m2   = ptr_reg - CNT_WIDTH'(2);
    assign ptr_p1   = ptr_reg + CNT_WIDTH'(1);
    assign ptr_p2   = ptr_reg + CNT_WIDTH'(2);
    // the signed comparator used by the insert walk
    assign greater  = $signed(mem_rdata) > $signed(val_reg);
    assign req_fire = req_valid && req_ready;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        val_next        = val_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        dump_more_next  = dump_more_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg[ADDR_WIDTH-1:0];
        mem_wdata       = mem_rdata;
        mem_raddr       = ptr_reg[ADDR_WIDTH-1:0];

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    res_last_next   = 1'b1;
                    dump_more_next  = 1'b0;
                    unique case (req.req_type)
                        REQ_INSERT:
                        begin
                            val_next = req.value;
                            ptr_next = cnt_reg;
                            if (cnt_reg == CNT_WIDTH'(TABLE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (cnt_reg == '0)
                            begin
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            ptr_next = CNT_WIDTH'(req.index);
                            if (CNT_WIDTH'(req.index) >= cnt_reg)
                            begin
                                res_status_next = ST_BADIDX;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RM_RD;
                            end
                        end
                        REQ_DUMP:
                        begin
                            ptr_next = '0;
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_DMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                mem_raddr  = ptr_m1[ADDR_WIDTH-1:0];
                state_next = S_INS_CMP;
            end

            // walk down from the top, moving each larger entry up by one
            S_INS_CMP:
            begin
                if (greater)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[ADDR_WIDTH-1:0];
                    mem_wdata = mem_rdata;
                    ptr_next  = ptr_m1;
                    mem_raddr = ptr_m2[ADDR_WIDTH-1:0];
                    if (ptr_m1 == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[ADDR_WIDTH-1:0];
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + CNT_WIDTH'(1);
                state_next = S_EMIT;
            end

            S_RM_RD:
            begin
                mem_raddr  = ptr_reg[ADDR_WIDTH-1:0];
                state_next = S_RM_TAKE;
            end

            S_RM_TAKE:
            begin
                res_data_next = mem_rdata;
                mem_raddr     = ptr_p1[ADDR_WIDTH-1:0];
                if (ptr_p1 < cnt_reg)
                begin
                    state_next = S_RM_MOVE;
                end
                else
                begin
                    state_next = S_RM_DONE;
                end
            end

            // read of ptr+1 lands now; write it down and fetch the next one
            S_RM_MOVE:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[ADDR_WIDTH-1:0];
                mem_wdata = mem_rdata;
                ptr_next  = ptr_p1;
                mem_raddr = ptr_p2[ADDR_WIDTH-1:0];
                if (ptr_p2 >= cnt_reg)
                begin
                    state_next = S_RM_DONE;
                end
            end

            S_RM_DONE:
            begin
                cnt_next   = cnt_reg - CNT_WIDTH'(1);
                state_next = S_EMIT;
            end

            S_DMP_RD:
            begin
                mem_raddr  = ptr_reg[ADDR_WIDTH-1:0];
                state_next = S_DMP_WAIT;
            end

            S_DMP_WAIT:
            begin
                res_data_next   = mem_rdata;
                res_status_next = ST_OK;
                res_last_next   = (ptr_p1 == cnt_reg);
                dump_more_next  = (ptr_p1 != cnt_reg);
                ptr_next        = ptr_p1;
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.data   = res_data_reg;
                    out_next.status = res_status_reg;
                    out_next.last   = res_last_reg;
                    out_next.count  = cnt_reg;
                    state_next      = dump_more_reg ? S_DMP_RD : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ptr_reg        <= '0;
            val_reg        <= '0;
            res_data_reg   <= '0;
            res_status_reg <= ST_OK;
            res_last_reg   <= 1'b0;
            dump_more_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ptr_reg        <= ptr_next;
            val_reg        <= val_next;
            res_data_reg   <= res_data_next;
            res_status_reg <= res_status_next;
            res_last_reg   <= res_last_next;
            dump_more_reg  <= dump_more_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_WIDTH'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req.req_type == REQ_INSERT || req.req_type == REQ_REMOVE
                     || req.req_type == REQ_DUMP) |=> !req_ready)
        else $error("request taken but sequencer did not go busy");

    a_nonlast_is_dump: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.status == ST_OK && rsp.count != '0)
        else $error("non-final transaction that is not a dump entry");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0)
        else $error("empty dump with nonzero count");

endmodule

`default_nettype wire

// ===== design/sti_store.sv =====
// Table storage: one write port, one read port with registered read data.
// Depends on sti_pkg for depth and widths.
`default_nettype none

module sti_store
    import sti_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [ADDR_WIDTH-1:0]  waddr,
    input  wire logic [VALUE_WIDTH-1:0] wdata,
    input  wire logic [ADDR_WIDTH-1:0]  raddr,
    output logic      [VALUE_WIDTH-1:0] rdata
);

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for sorted_table_insert_remove: a directed warm-up, then
// random insert/remove/dump traffic checked against an in-bench sorted-table predictor.
// Depends on sti_pkg and the sorted_table_insert_remove RTL.

module tb;

    import sti_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 3_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    // predictor state
    logic signed [VALUE_WIDTH-1:0] shadow_table [TABLE_DEPTH];
    int   shadow_count = 0;
    rsp_t due_rsps [$];

    // stimulus state
    req_t req_backlog [$];
    int   gen_count    = 0;
    int   req_idle_max = 13;
    int   rsp_idle_max = 13;
    int   req_gap      = 0;
    int   rsp_stall    = 0;
    int   err_cnt      = 0;
    int   cycle_cnt    = 0;

    always #6 clk = ~clk;

    sorted_table_insert_remove i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // at least a third of the draws are zero so back-to-back stretches show up often
    function automatic int draw_gap(int max_gap);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, max_gap);
    endfunction

    task automatic queue_rsp(logic signed [VALUE_WIDTH-1:0] data, logic [1:0] status,
                             logic last);
        rsp_t r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        r.count  = shadow_count[CNT_WIDTH-1:0];
        due_rsps.insert(due_rsps.size(), r);
    endtask

    // Applies one accepted request to the shadow table and queues its responses.
    task automatic apply_to_table(req_t r);
        int pos;
        int i;
        logic signed [VALUE_WIDTH-1:0] taken;
        case (r.req_type)
            REQ_INSERT:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    queue_rsp('0, ST_FULL, 1'b1);
                end
                else
                begin
                    // new value lands after any equal entries
                    pos = shadow_count;
                    while (pos > 0 && shadow_table[pos-1] > r.value)
                        pos--;
                    for (i = shadow_count; i > pos; i--)
                        shadow_table[i] = shadow_table[i-1];
                    shadow_table[pos] = r.value;
                    shadow_count++;
                    queue_rsp('0, ST_OK, 1'b1);
                end
            end
            REQ_REMOVE:
            begin
                if (r.index >= shadow_count)
                begin
                    queue_rsp('0, ST_BADIDX, 1'b1);
                end
                else
                begin
                    taken = shadow_table[r.index];
                    for (i = r.index; i + 1 < shadow_count; i++)
                        shadow_table[i] = shadow_table[i+1];
                    shadow_count--;
                    queue_rsp(taken, ST_OK, 1'b1);
                end
            end
            REQ_DUMP:
            begin
                if (shadow_count == 0)
                    queue_rsp('0, ST_EMPTY, 1'b1);
                else
                    for (i = 0; i < shadow_count; i++)
                        queue_rsp(shadow_table[i], ST_OK, i == shadow_count - 1);
            end
            default:
            begin
                // unused request type: no state change, no response
            end
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        err_cnt++;
        $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    endtask

    // request driver
    always @(posedge clk)
    begin : req_driver
        logic hold;
        hold = req_valid && !req_ready;
        if (rst_n && !hold)
        begin
            if (req_gap > 0)
            begin
                req_gap = req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
                req_gap = draw_gap(req_idle_max);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response back-pressure, one stall draw per transaction
    always @(posedge clk)
    begin : rsp_sink
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                rsp_stall = draw_gap(rsp_idle_max);
            if (rsp_stall > 0)
            begin
                rsp_stall = rsp_stall - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on request transactions, check response transactions
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsps.size() == 0)
                begin
                    report_mismatch("unexpected response, data", rsp.data, 0);
                end
                else
                begin
                    want = due_rsps.pop_front();
                    if (rsp.data !== want.data)
                        report_mismatch("data", rsp.data, want.data);
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.last !== want.last)
                        report_mismatch("last", rsp.last, want.last);
                    if (rsp.count !== want.count)
                        report_mismatch("count", rsp.count, want.count);
                end
            end
            if (req_valid && req_ready)
                apply_to_table(req);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Queues one request; gen_count follows the table fill so removes can aim at real entries.
    task automatic push_req(logic [1:0] kind, logic signed [VALUE_WIDTH-1:0] val, int idx);
        req_t r;
        r.req_type = kind;
        r.value    = val;
        r.index    = idx[ADDR_WIDTH-1:0];
        req_backlog.insert(req_backlog.size(), r);
        if (kind == REQ_INSERT && gen_count < TABLE_DEPTH)
            gen_count++;
        else if (kind == REQ_REMOVE && idx < gen_count)
            gen_count--;
    endtask

    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:
            begin
                // narrow range to force duplicates
                v = $urandom_range(0, 16);
                return v - 8;
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 2000);
                return v - 1000;
            end
        endcase
    endfunction

    task automatic run_mix(int n_items, int ins_pct, int rem_pct, int dump_pct);
        int done;
        int roll;
        int idx;
        done = 0;
        while (done < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
            begin
                push_req(REQ_INSERT, pick_value(), $urandom_range(0, 63));
                done++;
            end
            else if (roll < ins_pct + rem_pct)
            begin
                if (gen_count > 0 && $urandom_range(0, 99) < 85)
                    idx = $urandom_range(0, gen_count - 1);
                else
                    idx = $urandom_range(0, 63);
                push_req(REQ_REMOVE, $urandom, idx);
                done++;
            end
            else if (roll < ins_pct + rem_pct + dump_pct)
            begin
                push_req(REQ_DUMP, $urandom, $urandom_range(0, 63));
                done++;
            end
            else
            begin
                push_req(REQ_UNUSED, $urandom, $urandom_range(0, 63));
            end
        end
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (due_rsps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed warm-up
        push_req(REQ_DUMP, 0, 0);
        push_req(REQ_REMOVE, 0, 0);
        push_req(REQ_REMOVE, 0, 63);
        push_req(REQ_INSERT, 32'sh7FFF_FFFF, 0);
        push_req(REQ_INSERT, 32'sh8000_0000, 63);
        push_req(REQ_INSERT, 0, 0);
        push_req(REQ_INSERT, -1, 0);
        push_req(REQ_INSERT, 0, 0);
        push_req(REQ_INSERT, 1, 0);
        push_req(REQ_DUMP, -1, 63);
        push_req(REQ_REMOVE, 0, 5);
        push_req(REQ_REMOVE, 0, 5);
        push_req(REQ_REMOVE, -1, 0);
        push_req(REQ_UNUSED, 32'sh5A5A_A5A5, 42);
        push_req(REQ_INSERT, 32'sh8000_0000, 21);
        push_req(REQ_DUMP, 0, 0);
        drain();

        // fill toward full, so full-table inserts and top-index removes happen
        run_mix(140, 72, 14, 9);
        drain();

        // shrink to empty with no idling on either side
        req_idle_max = 0;
        rsp_idle_max = 0;
        run_mix(120, 15, 70, 10);
        drain();

        req_idle_max = 13;
        rsp_idle_max = 13;
        run_mix(100, 40, 40, 12);
        drain();

        // refill with a slow receiver and fast sender
        req_idle_max = 0;
        run_mix(104, 75, 12, 8);
        drain();

        repeat (300) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sorted_table_insert_remove.f =====
design/sti_pkg.sv
design/sti_store.sv
design/sorted_table_insert_remove.sv
tb/sv/tb.sv
